FILE: hw/rtl/plds_pkg.sv
// Shared types and constants of the point-light diffuse shader.
package plds_pkg;

  localparam int COORD_W = 24;
  localparam int DIFF_W  = 25;
  localparam int NORM_W  = 16;
  localparam int COEF_W  = 16;
  localparam int SUMSQ_W = 50;
  localparam int DOT_W   = 43;
  localparam int LEN_W   = 25;
  localparam int COS_W   = 17;
  localparam int COSN_W  = 44;
  localparam int KDIL_W  = 32;
  localparam int KC_W    = 49;
  localparam int PROD_W  = 63;
  localparam int FNUM_W  = 67;
  localparam int FAC_W   = 48;
  localparam int CFG_IDX_W = 3;

  // 500^2 / 16: the remaining factor of sixteen in the numerator is a shift.
  localparam logic [13:0] DIST_K = 14'd15625;
  localparam logic [FAC_W-1:0] FLOOR_Q16 = 48'd6554;
  localparam logic [FAC_W-1:0] FMAX = {FAC_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIGHT_X   = 3'd0,
    REG_LIGHT_Y   = 3'd1,
    REG_LIGHT_Z   = 3'd2,
    REG_DIFFUSE   = 3'd3,
    REG_INTENSITY = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } colour_t;

  typedef struct packed {
    logic [7:0]                base_blue;
    logic [7:0]                base_green;
    logic [7:0]                base_red;
    logic signed [NORM_W-1:0]  normal_z;
    logic signed [NORM_W-1:0]  normal_y;
    logic signed [NORM_W-1:0]  normal_x;
    logic signed [COORD_W-1:0] point_z;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_x;
  } hit_t;

  typedef struct packed {
    logic                     szero;
    colour_t                  col;
    logic signed [DOT_W-1:0]  dt;
    logic [SUMSQ_W-1:0]       sumsq;
  } sq_side_t;

  typedef struct packed {
    logic               szero;
    colour_t            col;
    logic [SUMSQ_W-1:0] sumsq;
  } cd_side_t;

  typedef struct packed {
    logic    szero;
    colour_t col;
  } fd_side_t;

endpackage

FILE: hw/rtl/plds_front.sv
// Front stages: light-to-point vector, squares, dot products and their sums.
module plds_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  plds_pkg::hit_t                       hit_i,
  input  logic signed [plds_pkg::COORD_W-1:0]  light_x_i,
  input  logic signed [plds_pkg::COORD_W-1:0]  light_y_i,
  input  logic signed [plds_pkg::COORD_W-1:0]  light_z_i,
  output logic                                 valid_o,
  output plds_pkg::sq_side_t                   side_o
);

  localparam int DW = plds_pkg::DIFF_W;
  localparam int NW = plds_pkg::NORM_W;
  localparam int PW = DW + NW;

  logic                 v1_q, v2_q, v3_q;
  logic signed [DW-1:0] dx_q, dy_q, dz_q;
  logic signed [NW-1:0] nx_q, ny_q, nz_q;
  plds_pkg::colour_t    col1_q, col2_q;
  logic [2*DW-2:0]      sqx_q, sqy_q, sqz_q;
  logic signed [PW-1:0] dotx_q, doty_q, dotz_q;
  logic                 zero2_q;
  plds_pkg::sq_side_t   side_q;

  logic signed [2*DW-1:0] sqx, sqy, sqz;
  logic signed [PW-1:0]   dotx, doty, dotz;

  assign sqx  = dx_q * dx_q;
  assign sqy  = dy_q * dy_q;
  assign sqz  = dz_q * dz_q;
  assign dotx = dx_q * nx_q;
  assign doty = dy_q * ny_q;
  assign dotz = dz_q * nz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q   <= DW'(hit_i.point_x) - DW'(light_x_i);
      dy_q   <= DW'(hit_i.point_y) - DW'(light_y_i);
      dz_q   <= DW'(hit_i.point_z) - DW'(light_z_i);
      nx_q   <= hit_i.normal_x;
      ny_q   <= hit_i.normal_y;
      nz_q   <= hit_i.normal_z;
      col1_q <= '{blue: hit_i.base_blue, green: hit_i.base_green, red: hit_i.base_red};

      sqx_q   <= sqx[2*DW-2:0];
      sqy_q   <= sqy[2*DW-2:0];
      sqz_q   <= sqz[2*DW-2:0];
      dotx_q  <= dotx;
      doty_q  <= doty;
      dotz_q  <= dotz;
      zero2_q <= (dx_q == '0) && (dy_q == '0) && (dz_q == '0);
      col2_q  <= col1_q;

      side_q.sumsq <= plds_pkg::SUMSQ_W'(sqx_q) + plds_pkg::SUMSQ_W'(sqy_q)
                    + plds_pkg::SUMSQ_W'(sqz_q);
      side_q.dt    <= plds_pkg::DOT_W'(dotx_q) + plds_pkg::DOT_W'(doty_q)
                    + plds_pkg::DOT_W'(dotz_q);
      side_q.col   <= col2_q;
      side_q.szero <= zero2_q;
    end
  end

  assign valid_o = v3_q;
  assign side_o  = side_q;

endmodule

FILE: hw/rtl/plds_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module plds_sqrt #(
  parameter int IW = 50,
  parameter int SW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [IW-1:0]   rad_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [IW/2-1:0] root_o,
  output logic [SW-1:0]   side_o
);

  localparam int K  = IW / 2;
  localparam int RW = K + 1;

  logic [RW-1:0] rem_q  [K];
  logic [K-1:0]  root_q [K];
  logic [IW-1:0] xs_q   [K];
  logic [SW-1:0] side_q [K];
  logic          vld_q  [K];

  for (genvar k = 0; k < K; k++) begin : g_stage
    logic [RW-1:0] rem_in;
    logic [K-1:0]  root_in;
    logic [IW-1:0] xs_in;
    logic [SW-1:0] side_in;
    logic          v_in;
    logic [RW:0]   rem_sh;
    logic [RW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign xs_in   = rad_i;
      assign side_in = side_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign xs_in   = xs_q[k-1];
      assign side_in = side_q[k-1];
      assign v_in    = vld_q[k-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    assign rem_sh = {rem_in[RW-2:0], xs_in[IW-1:IW-2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? RW'(rem_sh - trial) : RW'(rem_sh);
        root_q[k] <= {root_in[K-2:0], ge};
        xs_q[k]   <= {xs_in[IW-3:0], 2'b00};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[K-1];
  assign root_o  = root_q[K-1];
  assign side_o  = side_q[K-1];

endmodule

FILE: hw/rtl/plds_div.sv
// Pipelined restoring divider with overflow flag, one quotient bit per stage.
module plds_div #(
  parameter int NW = 44,
  parameter int DW = 25,
  parameter int QW = 17,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic          ovf_o,
  output logic [SW-1:0] side_o
);

  localparam int HW = NW - QW;
  localparam int CW = (HW > DW) ? HW : DW;

  logic [DW-1:0] rem_q  [QW+1];
  logic [QW-1:0] lo_q   [QW+1];
  logic [QW-1:0] quo_q  [QW+1];
  logic [DW-1:0] den_q  [QW+1];
  logic          ovf_q  [QW+1];
  logic [SW-1:0] side_q [QW+1];
  logic          vld_q  [QW+1];

  logic [HW-1:0] hi;
  assign hi = num_i[NW-1:QW];

  // The quotient fits in QW bits only when the upper part is below the divisor.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= DW'(hi);
      lo_q[0]   <= num_i[QW-1:0];
      quo_q[0]  <= '0;
      den_q[0]  <= den_i;
      ovf_q[0]  <= (CW'(hi) >= CW'(den_i));
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [DW:0] rem_sh;
    logic        ge;

    assign rem_sh = {rem_q[k-1], lo_q[k-1][QW-1]};
    assign ge     = (rem_sh >= {1'b0, den_q[k-1]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? DW'(rem_sh - {1'b0, den_q[k-1]}) : DW'(rem_sh);
        lo_q[k]   <= {lo_q[k-1][QW-2:0], 1'b0};
        quo_q[k]  <= {quo_q[k-1][QW-2:0], ge};
        den_q[k]  <= den_q[k-1];
        ovf_q[k]  <= ovf_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o = vld_q[QW];
  assign quo_o   = quo_q[QW];
  assign ovf_o   = ovf_q[QW];
  assign side_o  = side_q[QW];

endmodule

FILE: hw/rtl/point_light_diffuse_shade.sv
// Top level of the point-light diffuse shader: configuration, pipeline and output skid.
//
//  channel   dir  width  word
//  s_axis    in   144    one surface hit (point, normal, material colour)
//  m_axis    out  24     one shaded colour
//  cfg       in   24     light position, kd and illumination, write only
//
// One word is accepted every cycle while the skid register is empty.
// The depth comes mostly from the 25-stage square root and the 18- and 49-stage dividers.
// Reset clears all valid bits and loads the configuration registers with their reset values.
// A stall on m_axis parks the finished word in a skid register and freezes the
// whole pipeline until it is taken; nothing is lost or repeated.
module point_light_diffuse_shade #(
  parameter int COLOR_MAX = 255
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // point_x, point_y, point_z, normal_x, normal_y, normal_z,
  // base_red, base_green, base_blue
  input  logic [143:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // lit_red, lit_green, lit_blue
  output logic [23:0]  m_axis_tdata_o,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [23:0]  cfg_data_i
);

  localparam int VW = 40;

  // Configuration registers.
  logic signed [plds_pkg::COORD_W-1:0] light_x_q, light_y_q, light_z_q;
  logic [plds_pkg::COEF_W-1:0]         kd_q, illum_q;
  logic [plds_pkg::KDIL_W-1:0]         kdil_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_x_q <= '0;
      light_y_q <= '0;
      light_z_q <= '0;
      kd_q      <= 16'd256;
      illum_q   <= 16'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        plds_pkg::REG_LIGHT_X:   light_x_q <= cfg_data_i;
        plds_pkg::REG_LIGHT_Y:   light_y_q <= cfg_data_i;
        plds_pkg::REG_LIGHT_Z:   light_z_q <= cfg_data_i;
        plds_pkg::REG_DIFFUSE:   kd_q      <= cfg_data_i[15:0];
        plds_pkg::REG_INTENSITY: illum_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    kdil_q <= kd_q * illum_q;
  end

  // Global advance: the pipeline moves whenever the skid register is empty.
  logic en;
  logic skid_valid_q;
  plds_pkg::colour_t skid_q;

  assign en              = !skid_valid_q;
  assign s_axis_tready_o = en;

  // Front stages.
  plds_pkg::hit_t     hit;
  logic               fr_valid;
  plds_pkg::sq_side_t fr_side;

  assign hit = s_axis_tdata_i;

  plds_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (s_axis_tvalid_i),
    .hit_i     (hit),
    .light_x_i (light_x_q),
    .light_y_i (light_y_q),
    .light_z_i (light_z_q),
    .valid_o   (fr_valid),
    .side_o    (fr_side)
  );

  // Distance.
  logic                        sq_valid;
  logic [plds_pkg::LEN_W-1:0]  sq_len;
  plds_pkg::sq_side_t          sq_side;

  plds_sqrt #(
    .IW (plds_pkg::SUMSQ_W),
    .SW ($bits(plds_pkg::sq_side_t))
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .rad_i   (fr_side.sumsq),
    .side_i  (fr_side),
    .valid_o (sq_valid),
    .root_o  (sq_len),
    .side_o  (sq_side)
  );

  // Cosine: 4 * dot / length, zero when facing away, saturating on divider overflow.
  logic [plds_pkg::COSN_W-1:0] cos_num;
  plds_pkg::cd_side_t          cd_side_in, cd_side;
  logic                        cd_valid, cd_ovf;
  logic [plds_pkg::COS_W-1:0]  cd_quo, cosv;

  assign cos_num = (sq_side.dt > 0) ? {sq_side.dt[plds_pkg::DOT_W-2:0], 2'b00}
                                     : '0;
  assign cd_side_in = '{szero: sq_side.szero, col: sq_side.col, sumsq: sq_side.sumsq};

  plds_div #(
    .NW (plds_pkg::COSN_W),
    .DW (plds_pkg::LEN_W),
    .QW (plds_pkg::COS_W),
    .SW ($bits(plds_pkg::cd_side_t))
  ) u_cos_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .num_i   (cos_num),
    .den_i   (sq_len),
    .side_i  (cd_side_in),
    .valid_o (cd_valid),
    .quo_o   (cd_quo),
    .ovf_o   (cd_ovf),
    .side_o  (cd_side)
  );

  assign cosv = cd_ovf ? '1 : cd_quo;

  // Numerator of the factor: kd * illum * cosine * 250000, in two multiplies.
  logic                        m1_valid_q, m2_valid_q;
  logic [plds_pkg::KC_W-1:0]   kc_q;
  logic [plds_pkg::PROD_W-1:0] p_q;
  plds_pkg::cd_side_t          m1_side_q, m2_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_valid_q <= 1'b0;
      m2_valid_q <= 1'b0;
    end else if (en) begin
      m1_valid_q <= cd_valid;
      m2_valid_q <= m1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kc_q      <= kdil_q * cosv;
      m1_side_q <= cd_side;
      p_q       <= kc_q * plds_pkg::DIST_K;
      m2_side_q <= m1_side_q;
    end
  end

  // Factor: 16 * p / sumsq, saturating.
  logic [plds_pkg::FNUM_W-1:0] f_num;
  plds_pkg::fd_side_t          fd_side_in, fd_side;
  logic                        fd_valid, fd_ovf;
  logic [plds_pkg::FAC_W-1:0]  fd_quo;

  assign f_num      = {p_q, 4'b0000};
  assign fd_side_in = '{szero: m2_side_q.szero, col: m2_side_q.col};

  plds_div #(
    .NW (plds_pkg::FNUM_W),
    .DW (plds_pkg::SUMSQ_W),
    .QW (plds_pkg::FAC_W),
    .SW ($bits(plds_pkg::fd_side_t))
  ) u_fac_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m2_valid_q),
    .num_i   (f_num),
    .den_i   (m2_side_q.sumsq),
    .side_i  (fd_side_in),
    .valid_o (fd_valid),
    .quo_o   (fd_quo),
    .ovf_o   (fd_ovf),
    .side_o  (fd_side)
  );

  logic                       f_valid_q, pr_valid_q, last_valid_q;
  logic [plds_pkg::FAC_W-1:0] f_q;
  plds_pkg::colour_t          f_col_q, out_q;
  logic [plds_pkg::FAC_W+7:0] pr_r_q, pr_g_q, pr_b_q;
  logic [VW-1:0]              v_r, v_g, v_b, cmax;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q    <= 1'b0;
      pr_valid_q   <= 1'b0;
      last_valid_q <= 1'b0;
    end else if (en) begin
      f_valid_q    <= fd_valid;
      pr_valid_q   <= f_valid_q;
      last_valid_q <= pr_valid_q;
    end
  end

  // Light at the hit point saturates the factor; otherwise it never drops below 0.1.
  assign cmax = VW'(COLOR_MAX);
  assign v_r  = pr_r_q[plds_pkg::FAC_W+7:16];
  assign v_g  = pr_g_q[plds_pkg::FAC_W+7:16];
  assign v_b  = pr_b_q[plds_pkg::FAC_W+7:16];

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (fd_side.szero || fd_ovf) begin
        f_q <= plds_pkg::FMAX;
      end else if (fd_quo < plds_pkg::FLOOR_Q16) begin
        f_q <= plds_pkg::FLOOR_Q16;
      end else begin
        f_q <= fd_quo;
      end
      f_col_q <= fd_side.col;

      pr_r_q <= f_col_q.red   * f_q;
      pr_g_q <= f_col_q.green * f_q;
      pr_b_q <= f_col_q.blue  * f_q;

      out_q.red   <= (v_r > cmax) ? cmax[7:0] : v_r[7:0];
      out_q.green <= (v_g > cmax) ? cmax[7:0] : v_g[7:0];
      out_q.blue  <= (v_b > cmax) ? cmax[7:0] : v_b[7:0];
    end
  end

  // Skid register: holds a word that the sink refused while the pipeline advanced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      skid_valid_q <= !m_axis_tready_i;
    end else begin
      skid_valid_q <= last_valid_q && !m_axis_tready_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_valid_q) begin
      skid_q <= out_q;
    end
  end

  assign m_axis_tvalid_o = skid_valid_q || last_valid_q;
  assign m_axis_tdata_o  = skid_valid_q ? skid_q : out_q;

  a_skid_from_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(last_valid_q && !m_axis_tready_i))
    else $error("skid filled without a refused word");

  a_factor_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_valid_q |-> (f_q >= plds_pkg::FLOOR_Q16))
    else $error("shading factor below its floor");

  a_zero_dist_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fd_valid && en && fd_side.szero) |=> (f_q == plds_pkg::FMAX))
    else $error("zero distance did not saturate the factor");

  a_frozen_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |=> $stable(last_valid_q))
    else $error("pipeline moved while the skid register was full");

endmodule

FILE: bench/tb.sv
// Self-checking testbench for the point-light diffuse shader.
`timescale 1ns / 1ps

module tb;

  localparam int COLOR_MAX = 255;
  localparam int LATENCY = 100;
  localparam longint CYCLE_LIMIT = 400000;

  class shade_scoreboard;
    logic [23:0] light_x, light_y, light_z;
    logic [15:0] kd, illum;
    logic [23:0] colour_q[$];
    int errors;

    function new();
      light_x = '0; light_y = '0; light_z = '0;
      kd = 16'd256; illum = 16'd256;
      errors = 0;
    endfunction

    function void set_reg(plds_pkg::cfg_reg_e idx, logic [23:0] val);
      case (idx)
        plds_pkg::REG_LIGHT_X:   light_x = val;
        plds_pkg::REG_LIGHT_Y:   light_y = val;
        plds_pkg::REG_LIGHT_Z:   light_z = val;
        plds_pkg::REG_DIFFUSE:   kd = val[15:0];
        plds_pkg::REG_INTENSITY: illum = val[15:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] scale_channel(logic [7:0] m, logic [47:0] f);
      logic [63:0] v;
      v = (64'(m) * 64'(f)) >> 16;
      if (v > 64'(COLOR_MAX)) v = 64'(COLOR_MAX);
      return v[7:0];
    endfunction

    function logic [23:0] shade_hit(logic [143:0] w);
      longint dx, dy, dz, nx, ny, nz, dt;
      logic [63:0] s, len, c, kdil, p, q, rem, f, bit_v, v;
      dx = longint'($signed(w[23:0]))  - longint'($signed(light_x));
      dy = longint'($signed(w[47:24])) - longint'($signed(light_y));
      dz = longint'($signed(w[71:48])) - longint'($signed(light_z));
      nx = longint'($signed(w[87:72]));
      ny = longint'($signed(w[103:88]));
      nz = longint'($signed(w[119:104]));
      s = dx * dx + dy * dy + dz * dz;
      if (s == 0) begin
        f = 64'(plds_pkg::FMAX);
      end else begin
        dt = dx * nx + dy * ny + dz * nz;
        // Integer square root, bit by bit.
        v = s; len = 0; bit_v = 64'd1 << 62;
        while (bit_v > v) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
          if (v >= len + bit_v) begin
            v = v - (len + bit_v);
            len = (len >> 1) + bit_v;
          end else len = len >> 1;
          bit_v = bit_v >> 2;
        end
        c = 0;
        if (dt > 0) begin
          c = (64'(dt) * 4) / len;
          if (c > 64'd131071) c = 64'd131071;
        end
        kdil = 64'(kd) * 64'(illum);
        p = kdil * c * 64'd15625;
        q = p / s;
        rem = p % s;
        if (q > (64'(plds_pkg::FMAX) >> 4)) f = 64'(plds_pkg::FMAX);
        else begin
          f = q * 16 + (rem * 16) / s;
          if (f > 64'(plds_pkg::FMAX)) f = 64'(plds_pkg::FMAX);
        end
        if (f < 64'(plds_pkg::FLOOR_Q16)) f = 64'(plds_pkg::FLOOR_Q16);
      end
      return {scale_channel(w[143:136], f[47:0]), scale_channel(w[135:128], f[47:0]),
              scale_channel(w[127:120], f[47:0])};
    endfunction

    function void note_hit(logic [143:0] w);
      colour_q.push_back(shade_hit(w));
    endfunction

    task automatic report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task automatic check_colour(logic [23:0] got);
      logic [23:0] exp_c;
      if (colour_q.size() == 0) begin
        report($sformatf("unexpected colour %h", got));
        return;
      end
      exp_c = colour_q.pop_front();
      if (got[7:0] !== exp_c[7:0])
        report($sformatf("red got %h want %h", got[7:0], exp_c[7:0]));
      if (got[15:8] !== exp_c[15:8])
        report($sformatf("green got %h want %h", got[15:8], exp_c[15:8]));
      if (got[23:16] !== exp_c[23:16])
        report($sformatf("blue got %h want %h", got[23:16], exp_c[23:16]));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [143:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [23:0] cfg_data_i = '0;

  shade_scoreboard sb = new();
  longint cycle_count = 0;
  bit quiet_tail = 0;

  point_light_diffuse_shade #(.COLOR_MAX(COLOR_MAX)) DUT (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Output side: check accepted words, stall in random bursts.
  initial begin : sink
    int gap;
    gap = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_colour(m_axis_tdata_o);
      if (quiet_tail) m_axis_tready_i <= 1'b1;
      else if (gap > 0) begin
        gap--;
        m_axis_tready_i <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        gap = $urandom_range(0, 15);
        m_axis_tready_i <= 1'b0;
      end else m_axis_tready_i <= 1'b1;
    end
  end

  task automatic write_reg(plds_pkg::cfg_reg_e idx, logic [23:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    sb.set_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (sb.colour_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic send_hit(logic [143:0] w);
    int gap;
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= w;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_hit(w);
  endtask

  task automatic idle_input();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [23:0] rand_coord(int spread);
    // Mostly near the light so the factor lands in range; sometimes anywhere.
    if ($urandom_range(0, 3) == 0) return 24'($urandom);
    return 24'($signed($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function automatic logic [143:0] rand_hit();
    logic [143:0] w;
    int sp;
    sp = 1 << $urandom_range(4, 18);
    w[23:0] = rand_coord(sp);
    w[47:24] = rand_coord(sp);
    w[71:48] = rand_coord(sp);
    w[87:72] = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                         : 16'($signed($urandom_range(0, 32768)) - 16384);
    w[103:88] = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                           : 16'($signed($urandom_range(0, 32768)) - 16384);
    w[119:104] = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                            : 16'($signed($urandom_range(0, 32768)) - 16384);
    w[143:120] = 24'($urandom);
    return w;
  endfunction

  initial begin : stimulus
    logic [143:0] w;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: light at the hit point, facing away, unit facing, extremes.
    send_hit({24'hFF80FF, 16'h4000, 16'h0, 16'h0, 72'h0});
    send_hit({24'h010203, 16'h0, 16'h0, 16'h4000, 24'h0, 24'h0, 24'h000100});
    send_hit({24'hFFFFFF, 16'h0, 16'h0, 16'hC000, 24'h0, 24'h0, 24'h000100});
    send_hit({24'hFFFFFF, 16'h0, 16'h0, 16'h0, 24'h0, 24'h0, 24'h000100});
    send_hit({24'hFFFFFF, 16'h0, 16'h0, 16'h7FFF, 24'h0, 24'h0, 24'h000001});
    send_hit({24'hFFFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF});
    send_hit({24'hFFFFFF, 16'h8000, 16'h8000, 16'h8000, 24'h800000, 24'h800000, 24'h800000});
    send_hit({24'hFFFFFF, 16'h4000, 16'h0, 16'h0, 24'h0, 24'h0, 24'h800000});
    send_hit({24'h808080, 16'h2D41, 16'h2D41, 16'h0, 24'h0, 24'h000500, 24'h000500});
    idle_input();

    // Extreme configuration, written once the pipeline has drained.
    drain();
    write_reg(plds_pkg::REG_LIGHT_X, 24'h7FFFFF);
    write_reg(plds_pkg::REG_LIGHT_Y, 24'h800000);
    write_reg(plds_pkg::REG_LIGHT_Z, 24'hFFFFFF);
    write_reg(plds_pkg::REG_DIFFUSE, 24'h00FFFF);
    write_reg(plds_pkg::REG_INTENSITY, 24'h00FFFF);
    send_hit({24'hFFFFFF, 16'h7FFF, 16'h8000, 16'h0, 24'hFFFFFF, 24'h800000, 24'h7FFFFF});
    send_hit({24'hFFFFFF, 16'h4000, 16'h0, 16'h0, 24'hFFFFFF, 24'h800000, 24'h800000});
    send_hit({24'hFFFFFF, 16'h0, 16'h0, 16'h4000, 24'h0, 24'h0, 24'h0});
    idle_input();
    drain();
    write_reg(plds_pkg::REG_DIFFUSE, 24'h0);
    write_reg(plds_pkg::REG_INTENSITY, 24'h0);
    send_hit({24'hFFFFFF, 16'h4000, 16'h0, 16'h0, 24'h0, 24'h0, 24'h0});
    send_hit({24'h123456, 16'h4000, 16'h0, 16'h0, 24'h7FFFFF, 24'h800000, 24'hFFFFFF});
    idle_input();

    // Random phases, each with a fresh light setting.
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      write_reg(plds_pkg::REG_LIGHT_X, rand_coord(1 << 12));
      write_reg(plds_pkg::REG_LIGHT_Y, rand_coord(1 << 12));
      write_reg(plds_pkg::REG_LIGHT_Z, rand_coord(1 << 12));
      write_reg(plds_pkg::REG_DIFFUSE,
                24'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1024)));
      write_reg(plds_pkg::REG_INTENSITY,
                24'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1024)));
      if (ph == 7) quiet_tail = 1;
      for (int i = 0; i < 50; i++) begin
        w = rand_hit();
        send_hit(w);
      end
      idle_input();
    end

    while (sb.colour_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
